// ===== src/rmt_pkg.sv =====
// Running median tracker: shared package.
// Sample and result widths, capacity default and the select-tree grouping.
// No dependencies.
`timescale 1ns / 1ps

package rmt_pkg;

  localparam int SAMPLE_W         = 32;
  localparam int MEDIAN_W         = 33;
  localparam int KEPT_W           = 9;
  localparam int DEFAULT_CAPACITY = 256;
  localparam int GROUP_SIZE       = 16;
  localparam int OUT_TDATA_W      = 48;
  localparam int OUT_PAD_W        = OUT_TDATA_W - MEDIAN_W - KEPT_W;

endpackage

// ===== src/rmt_sort_array.sv =====
// Running median tracker: sorted insertion array of compare-and-shift cells.
// Every cell compares with the new sample at once; registers the median indices.
// Depends on rmt_pkg.
`timescale 1ns / 1ps

module rmt_sort_array
  import rmt_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ins,
  input  logic [SAMPLE_W-1:0]                sample,
  output logic [CAPACITY-1:0][SAMPLE_W-1:0]  cells,
  output logic [$clog2(CAPACITY)-1:0]        hi_idx,
  output logic [$clog2(CAPACITY)-1:0]        lo_idx,
  output logic [KEPT_W-1:0]                  kept,
  output logic                               dropped
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  logic [CAPACITY-1:0][SAMPLE_W-1:0]  cells_next;
  logic [CAPACITY-1:0]                le;
  logic                               full;
  logic [IW-1:0]                      hi_next;
  logic [IW-1:0]                      lo_next;
  logic [CW+KEPT_W-1:0]               kept_ext;

  assign full = (count == CW'(CAPACITY));

  // le marks the stored prefix not greater than the sample; insert just after it
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign le[i] = (CW'(i) < count) && ($signed(cells[i]) <= $signed(sample));
    if (i == 0) begin : g_first
      assign cells_next[i] = le[i] ? cells[i] : sample;
    end else begin : g_rest
      assign cells_next[i] = le[i] ? cells[i] : (le[i-1] ? sample : cells[i-1]);
    end
  end

  assign count_next = full ? count : count + 1'b1;
  assign hi_next    = IW'(count_next >> 1);
  assign lo_next    = count_next[0] ? hi_next : hi_next - 1'b1;
  assign kept_ext   = {{KEPT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ins) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      if (!full) begin
        cells <= cells_next;
      end
      hi_idx  <= hi_next;
      lo_idx  <= lo_next;
      kept    <= kept_ext[KEPT_W-1:0];
      dropped <= full;
    end
  end

endmodule

// ===== src/rmt_median_select.sv =====
// Running median tracker: two-stage registered select of the middle cells.
// Group partials, then final merge and the doubled-median sum.
// Depends on rmt_pkg.
`timescale 1ns / 1ps

module rmt_median_select
  import rmt_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                               clk,
  input  logic                               ld_group,
  input  logic                               ld_out,
  input  logic [CAPACITY-1:0][SAMPLE_W-1:0]  cells,
  input  logic [$clog2(CAPACITY)-1:0]        hi_idx,
  input  logic [$clog2(CAPACITY)-1:0]        lo_idx,
  input  logic [KEPT_W-1:0]                  kept_in,
  input  logic                               dropped_in,
  output logic [MEDIAN_W-1:0]                median_twice,
  output logic [KEPT_W-1:0]                  kept_count,
  output logic                               dropped
);

  localparam int IW = $clog2(CAPACITY);
  localparam int NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [NG-1:0][SAMPLE_W-1:0] lo_part_next;
  logic [NG-1:0][SAMPLE_W-1:0] hi_part_next;
  logic [NG-1:0][SAMPLE_W-1:0] lo_part;
  logic [NG-1:0][SAMPLE_W-1:0] hi_part;
  logic [KEPT_W-1:0]           kept_g;
  logic                        dropped_g;
  logic [SAMPLE_W-1:0]         lo_sel;
  logic [SAMPLE_W-1:0]         hi_sel;
  logic [MEDIAN_W-1:0]         sum;

  for (genvar g = 0; g < NG; g++) begin : g_group
    always_comb begin
      lo_part_next[g] = '0;
      hi_part_next[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < CAPACITY) begin
          if (lo_idx == IW'(g * GROUP_SIZE + j)) begin
            lo_part_next[g] = lo_part_next[g] | cells[g * GROUP_SIZE + j];
          end
          if (hi_idx == IW'(g * GROUP_SIZE + j)) begin
            hi_part_next[g] = hi_part_next[g] | cells[g * GROUP_SIZE + j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_group) begin
      lo_part   <= lo_part_next;
      hi_part   <= hi_part_next;
      kept_g    <= kept_in;
      dropped_g <= dropped_in;
    end
  end

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int g = 0; g < NG; g++) begin
      lo_sel = lo_sel | lo_part[g];
      hi_sel = hi_sel | hi_part[g];
    end
  end

  // odd count: both indices name the middle cell, so the sum doubles it
  assign sum = {lo_sel[SAMPLE_W-1], lo_sel} + {hi_sel[SAMPLE_W-1], hi_sel};

  always_ff @(posedge clk) begin
    if (ld_out) begin
      median_twice <= sum;
      kept_count   <= kept_g;
      dropped      <= dropped_g;
    end
  end

endmodule

// ===== src/running_median_tracker_core.sv =====
// Running median tracker top level: one sample per word in, one doubled median out.
// Throughput one word per cycle while m_tready does not hold the output.
// Stages: input register, sorted cell array, group select, output register.
// Reset (synchronous, active high) empties the store and all stage valid flags.
// Depends on rmt_pkg, rmt_sort_array, rmt_median_select.
`timescale 1ns / 1ps

module running_median_tracker_core
  import rmt_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_W-1:0]    s_tdata,   // [31:0] sample
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [32:0] median_twice, [41:33] kept_count, pad
  output logic                   m_tuser    // [0] dropped
);

  localparam int IW = $clog2(CAPACITY);

  logic                               in_valid;
  logic [SAMPLE_W-1:0]                in_sample;
  logic                               arr_valid;
  logic                               grp_valid;
  logic                               ld_in;
  logic                               ld_arr;
  logic                               ld_grp;
  logic                               ld_out;
  logic [CAPACITY-1:0][SAMPLE_W-1:0]  cells;
  logic [IW-1:0]                      hi_idx;
  logic [IW-1:0]                      lo_idx;
  logic [KEPT_W-1:0]                  arr_kept;
  logic                               arr_dropped;
  logic [MEDIAN_W-1:0]                median_twice;
  logic [KEPT_W-1:0]                  kept_count;
  logic                               dropped;

  assign ld_out   = grp_valid && (!m_tvalid || m_tready);
  assign ld_grp   = arr_valid && (!grp_valid || ld_out);
  assign ld_arr   = in_valid && (!arr_valid || ld_grp);
  assign s_tready = !in_valid || ld_arr;
  assign ld_in    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      arr_valid <= 1'b0;
      grp_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      in_valid  <= ld_in || (in_valid && !ld_arr);
      arr_valid <= ld_arr || (arr_valid && !ld_grp);
      grp_valid <= ld_grp || (grp_valid && !ld_out);
      m_tvalid  <= ld_out || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in) begin
      in_sample <= s_tdata;
    end
  end

  rmt_sort_array #(
    .CAPACITY (CAPACITY)
  ) u_array (
    .clk     (clk),
    .rst     (rst),
    .ins     (ld_arr),
    .sample  (in_sample),
    .cells   (cells),
    .hi_idx  (hi_idx),
    .lo_idx  (lo_idx),
    .kept    (arr_kept),
    .dropped (arr_dropped)
  );

  rmt_median_select #(
    .CAPACITY (CAPACITY)
  ) u_select (
    .clk          (clk),
    .ld_group     (ld_grp),
    .ld_out       (ld_out),
    .cells        (cells),
    .hi_idx       (hi_idx),
    .lo_idx       (lo_idx),
    .kept_in      (arr_kept),
    .dropped_in   (arr_dropped),
    .median_twice (median_twice),
    .kept_count   (kept_count),
    .dropped      (dropped)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, kept_count, median_twice};
  assign m_tuser = dropped;

`ifndef NO_ASSERTIONS
  localparam logic [KEPT_W-1:0] KEPT_FULL = KEPT_W'(CAPACITY);

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stage empty but not ready");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[MEDIAN_W+KEPT_W-1:MEDIAN_W] == KEPT_FULL))
    else $error("word dropped while store not full");

  a_kept_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser && CAPACITY < 512) |-> (m_tdata[MEDIAN_W+KEPT_W-1:MEDIAN_W] != '0))
    else $error("kept count zero after insert");

  a_out_follows_group: assert property (@(posedge clk) disable iff (rst)
    ld_out |=> m_tvalid)
    else $error("output word lost after load");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for running_median_tracker_core: streams signed samples in, checks each doubled
// median word against a sorted-store predictor, with random idling and output stalls.
// Depends on rmt_pkg and running_median_tracker_core.
`timescale 1ns / 1ps

module tb
  import rmt_pkg::*;
();

  localparam int STORE_DEPTH = DEFAULT_CAPACITY;
  localparam int FLUSH_CYCLES = 20;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_twice;
    logic [KEPT_W-1:0]          kept_count;
    logic                       dropped;
  } median_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  logic signed [SAMPLE_W-1:0] sorted_store[$];
  median_word_t               pending_medians[$];
  int                         errors = 0;
  int                         hold_len = 0;
  bit                         no_idle = 1'b0;

  running_median_tracker_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Insert into the sorted copy (after equal samples) and form the doubled median.
  function automatic median_word_t insert_sample(input logic signed [SAMPLE_W-1:0] value);
    median_word_t res;
    int pos;
    int n;
    res.dropped = 1'b0;
    if (sorted_store.size() >= STORE_DEPTH) begin
      res.dropped = 1'b1;
    end else begin
      pos = 0;
      while (pos < sorted_store.size() && sorted_store[pos] <= value) pos++;
      sorted_store.insert(pos, value);
    end
    n = sorted_store.size();
    if (n % 2 == 1) begin
      res.median_twice = {sorted_store[n/2], 1'b0};
    end else begin
      res.median_twice = {sorted_store[n/2-1][SAMPLE_W-1], sorted_store[n/2-1]}
                       + {sorted_store[n/2][SAMPLE_W-1], sorted_store[n/2]};
    end
    res.kept_count = KEPT_W'(n);
    return res;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    pending_medians.push_back(insert_sample(value));
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_medians.size() != 0);
  endtask

  // Output side: random stall per word, or a long hold when one is requested.
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (hold_len != 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready) && hold_len == 0);
    end
  end

  always @(posedge clk) begin
    median_word_t exp_w;
    median_word_t act_w;
    if (!rst && m_tvalid && m_tready) begin
      act_w.median_twice = m_tdata[MEDIAN_W-1:0];
      act_w.kept_count   = m_tdata[MEDIAN_W +: KEPT_W];
      act_w.dropped      = m_tuser;
      if (pending_medians.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, actual median_twice %0d kept %0d dropped %0b",
                 $time, act_w.median_twice, act_w.kept_count, act_w.dropped);
      end else begin
        exp_w = pending_medians.pop_front();
        if (act_w.median_twice !== exp_w.median_twice) begin
          errors++;
          $display("%0t median_twice: expected %0d, actual %0d",
                   $time, exp_w.median_twice, act_w.median_twice);
        end
        if (act_w.kept_count !== exp_w.kept_count) begin
          errors++;
          $display("%0t kept_count: expected %0d, actual %0d",
                   $time, exp_w.kept_count, act_w.kept_count);
        end
        if (act_w.dropped !== exp_w.dropped) begin
          errors++;
          $display("%0t dropped: expected %0b, actual %0b",
                   $time, exp_w.dropped, act_w.dropped);
        end
      end
    end
  end

  // Both middle samples at the minimum, then min plus max, then both at the maximum.
  task automatic test_extremes();
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0000_0000);
    send_sample(32'shFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_equal_samples();
    send_sample(32'sd3);
    send_sample(32'sd3);
    send_sample(32'sd3);
    send_sample(-32'sd3);
    send_sample(32'sd3);
    wait_drained();
  endtask

  // Long output hold while input keeps coming, so the block fills and stalls its input.
  task automatic test_output_stall();
    no_idle = 1'b1;
    hold_len = 150;
    for (int i = 0; i < 40; i++) send_sample($urandom);
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Random mix; runs past the capacity so the store-full path is exercised too.
  task automatic test_random_fill();
    logic signed [SAMPLE_W-1:0] v;
    for (int i = 0; i < 450; i++) begin
      if (i % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $signed($urandom_range(0, 16)) - 8;
        2: v = $urandom_range(0, 1) ? 32'sh7FFF_FFF0 + $urandom_range(0, 15)
                                    : 32'sh8000_0000 + $urandom_range(0, 15);
        default: v = $signed($urandom_range(0, 2000)) - 1000;
      endcase
      send_sample(v);
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_equal_samples();
    test_output_stall();
    test_random_fill();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
